// ----- rtl/gtsr_pkg.sv -----
// Package for the glyph text span renderer: payload structs, command codes,
// sequencer states and shared constants. No dependencies.
package gtsr_pkg;

  localparam int GLYPH_MAX_WIDTH = 24;
  localparam int GLYPH_MAX_ROWS  = 24;
  localparam int FIRST_CODE      = 32;
  localparam int ENTRY_COUNT     = 96;

  localparam int MAX_SPANS       = 24;
  localparam int MASK_W          = 24;
  localparam int ALPHA_THRESHOLD = 127;
  localparam int SCREEN_LIMIT    = 4096;
  localparam logic [7:0] NEWLINE_CODE = 8'd10;
  localparam logic [7:0] LOWER_A      = 8'd97;
  localparam logic [7:0] LOWER_Z      = 8'd122;
  localparam logic [7:0] CASE_OFFSET  = 8'd32;

  typedef enum logic [1:0] {
    CMD_START = 2'd0,
    CMD_CHAR  = 2'd1,
    CMD_METRIC = 2'd2,
    CMD_ALPHA = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    REG_SCREEN_WIDTH    = 3'd0,
    REG_SCREEN_HEIGHT   = 3'd1,
    REG_BASELINE_OFFSET = 3'd2,
    REG_UNKNOWN_ADVANCE = 3'd3,
    REG_LINE_ADVANCE    = 3'd4,
    REG_DRAW_COLOR      = 3'd5
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROW,
    ST_PIX,
    ST_EMIT,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [1:0]        cmd;
    logic [7:0]        code;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic [9:0]        pixel_index;
    logic [7:0]        alpha;
    logic [4:0]        glyph_width;
    logic [4:0]        glyph_height;
    logic signed [7:0] glyph_xoff;
    logic signed [7:0] glyph_yoff;
    logic [7:0]        glyph_advance;
    logic              glyph_valid;
  } in_item_t;

  typedef struct packed {
    logic [11:0]        row_y;
    logic signed [15:0] first_x;
    logic [23:0]        column_mask;
    logic               last;
  } out_item_t;

  typedef struct packed {
    logic [4:0]        w;
    logic [4:0]        h;
    logic signed [7:0] xoff;
    logic signed [7:0] yoff;
    logic [7:0]        adv;
  } metric_t;

endpackage

// ----- rtl/glyph_text_span_renderer.sv -----
// Glyph text span renderer top level: sequencer, pen state, metric and alpha RAMs.
// Depends on gtsr_pkg and gtsr_ram.
// Items are taken one at a time; in_stall is high until the sequencer is idle again.
// A drawn character walks its glyph rows: a visible row reads one alpha byte per cycle,
// drains the read, sets up and sends the span (out_stall can hold it); off-screen rows skip.
// Reset clears pen, registers and all metric valid bits at once; alpha store is not cleared.
module glyph_text_span_renderer
  import gtsr_pkg::*;
#(
  parameter int P_ENTRY_COUNT = ENTRY_COUNT
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int GLYPH_AREA = GLYPH_MAX_WIDTH * GLYPH_MAX_ROWS;
  localparam int EW = (P_ENTRY_COUNT > 1) ? $clog2(P_ENTRY_COUNT) : 1;
  localparam int AW = $clog2(P_ENTRY_COUNT * GLYPH_AREA);
  localparam int MW = $bits(metric_t);

  // configuration
  logic [12:0] scr_w_r, scr_h_r;
  logic [5:0]  base_r, unk_r, lnadv_r;
  logic [15:0] color_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scr_w_r <= 13'd320;
      scr_h_r <= 13'd240;
      base_r  <= 6'd15;
      unk_r   <= 6'd8;
      lnadv_r <= 6'd24;
      color_r <= 16'hFFFF;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_SCREEN_WIDTH:    scr_w_r <= cfg_data[12:0];
        REG_SCREEN_HEIGHT:   scr_h_r <= cfg_data[12:0];
        REG_BASELINE_OFFSET: base_r  <= cfg_data[5:0];
        REG_UNKNOWN_ADVANCE: unk_r   <= cfg_data[5:0];
        REG_LINE_ADVANCE:    lnadv_r <= cfg_data[5:0];
        REG_DRAW_COLOR:      color_r <= cfg_data;
        default: ;
      endcase
    end
  end
  assign cfg_ready = 1'b1;

  logic [12:0] sw, sh;
  assign sw = (scr_w_r > 13'(SCREEN_LIMIT)) ? 13'(SCREEN_LIMIT) : scr_w_r;
  assign sh = (scr_h_r > 13'(SCREEN_LIMIT)) ? 13'(SCREEN_LIMIT) : scr_h_r;

  // input decode
  logic in_acc;
  assign in_acc = in_valid && !in_stall;

  logic [7:0] fcode;
  logic       in_tab;
  logic [EW-1:0] in_ent;
  logic [8:0] rel;
  always_comb begin
    fcode = in_data.code;
    if (in_data.cmd == CMD_CHAR && fcode >= LOWER_A && fcode <= LOWER_Z)
      fcode = fcode - CASE_OFFSET;
    rel    = {1'b0, fcode} - 9'(FIRST_CODE);
    in_tab = (fcode >= 8'(FIRST_CODE)) && (rel < 9'(P_ENTRY_COUNT));
    in_ent = rel[EW-1:0];
  end

  // metric valid bits and RAM
  logic [P_ENTRY_COUNT-1:0] mvalid_r;
  logic    met_we;
  metric_t met_wd, met_rd;
  logic    mok;
  assign met_we = in_acc && in_data.cmd == CMD_METRIC && in_tab;
  assign met_wd = '{w: in_data.glyph_width, h: in_data.glyph_height,
                    xoff: in_data.glyph_xoff, yoff: in_data.glyph_yoff,
                    adv: in_data.glyph_advance};
  assign mok = in_data.glyph_valid && in_data.glyph_width <= 5'(GLYPH_MAX_WIDTH)
               && in_data.glyph_height <= 5'(GLYPH_MAX_ROWS);

  always_ff @(posedge clk) begin
    if (!rst_n) mvalid_r <= '0;
    else if (met_we) mvalid_r[in_ent] <= mok;
  end

  gtsr_ram #(.WIDTH(MW), .DEPTH(P_ENTRY_COUNT)) u_met (
    .clk, .wr_en(met_we), .wr_addr(in_ent), .wr_data(met_wd),
    .rd_addr(in_ent), .rd_data(met_rd)
  );

  // alpha RAM; read address from the sequencer
  logic          al_we;
  logic [AW-1:0] al_wa, al_ra, base_addr_r, base_addr_nxt;
  logic [7:0]    al_rd;
  assign al_we = in_acc && in_data.cmd == CMD_ALPHA && in_tab
                 && in_data.pixel_index < 10'(GLYPH_AREA);
  assign al_wa = AW'(in_ent) * AW'(GLYPH_AREA) + AW'(in_data.pixel_index);

  gtsr_ram #(.WIDTH(8), .DEPTH(P_ENTRY_COUNT * GLYPH_AREA)) u_alpha (
    .clk, .wr_en(al_we), .wr_addr(al_wa), .wr_data(in_data.alpha),
    .rd_addr(al_ra), .rd_data(al_rd)
  );

  // sequencer
  state_t st_r, st_nxt;
  logic signed [15:0] pen_x_r, pen_x_nxt, pen_y_r, pen_y_nxt, lsx_r, lsx_nxt;
  logic        draw_r, draw_nxt;
  logic [EW-1:0] ent_r, ent_nxt;
  metric_t     g_r, g_nxt;
  logic [4:0]  row_r, row_nxt, col_r, col_nxt;
  logic [9:0]  idx_r, idx_nxt;  // row*w + col, accumulated
  logic [4:0]  nsp_r, nsp_nxt;  // spans given so far
  logic [23:0] mask_r, mask_nxt;
  logic [11:0] py_r, py_nxt;
  logic        pend_r, pend_nxt;  // a read issued last cycle for column pcol_r
  logic [4:0]  pcol_r, pcol_nxt;
  logic        pon_r, pon_nxt;
  out_item_t   obuf_r, obuf_nxt;
  out_item_t   hbuf_r, hbuf_nxt;
  logic        oval_r, oval_nxt;
  logic        hold_r, hold_nxt;  // finished span waiting for a later visible row or the glyph end

  logic signed [17:0] fx18, py18, px18;
  logic               row_vis;

  assign fx18 = 18'(pen_x_r) + 18'(g_r.xoff);
  assign py18 = 18'(pen_y_r) + 18'(base_r) + 18'(g_r.yoff) + 18'(row_r);
  assign row_vis = py18 >= 0 && py18 < 18'(sh);
  assign px18 = fx18 + 18'(col_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
      pen_x_r <= '0; pen_y_r <= '0; lsx_r <= '0;
      oval_r <= 1'b0; hold_r <= 1'b0; pend_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      pen_x_r <= pen_x_nxt; pen_y_r <= pen_y_nxt; lsx_r <= lsx_nxt;
      oval_r <= oval_nxt; hold_r <= hold_nxt; pend_r <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    draw_r <= draw_nxt; ent_r <= ent_nxt; g_r <= g_nxt;
    row_r <= row_nxt; col_r <= col_nxt; idx_r <= idx_nxt; nsp_r <= nsp_nxt;
    mask_r <= mask_nxt; py_r <= py_nxt; pcol_r <= pcol_nxt; pon_r <= pon_nxt;
    obuf_r <= obuf_nxt; hbuf_r <= hbuf_nxt; base_addr_r <= base_addr_nxt;
  end

  assign in_stall  = (st_r != ST_IDLE);
  assign out_valid = oval_r;
  assign out_data  = obuf_r;
  assign al_ra     = base_addr_r + AW'(idx_r);

  always_comb begin
    st_nxt = st_r;
    pen_x_nxt = pen_x_r; pen_y_nxt = pen_y_r; lsx_nxt = lsx_r;
    draw_nxt = draw_r; ent_nxt = ent_r; g_nxt = g_r;
    row_nxt = row_r; col_nxt = col_r; idx_nxt = idx_r; nsp_nxt = nsp_r;
    mask_nxt = mask_r; py_nxt = py_r; pcol_nxt = pcol_r; pon_nxt = pon_r;
    obuf_nxt = obuf_r; hbuf_nxt = hbuf_r; base_addr_nxt = base_addr_r;
    oval_nxt = oval_r && out_stall;
    hold_nxt = hold_r;
    pend_nxt = 1'b0;

    unique case (st_r)
      ST_IDLE: begin
        if (in_acc) begin
          draw_nxt = 1'b0;
          unique case (cmd_t'(in_data.cmd))
            CMD_START: begin
              pen_x_nxt = in_data.pos_x;
              lsx_nxt   = in_data.pos_x;
              pen_y_nxt = in_data.pos_y;
            end
            CMD_CHAR: begin
              if (in_data.code == NEWLINE_CODE) begin
                pen_y_nxt = pen_y_r + 16'(lnadv_r);
                pen_x_nxt = lsx_r;
              end else if (in_tab && mvalid_r[in_ent]) begin
                draw_nxt = 1'b1;
                ent_nxt  = in_ent;
              end else begin
                pen_x_nxt = pen_x_r + 16'(unk_r);
              end
            end
            default: ;
          endcase
          st_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        // metric read data is valid here
        if (draw_r) begin
          g_nxt = met_rd;
          row_nxt = '0; col_nxt = '0; idx_nxt = '0; nsp_nxt = '0;
          base_addr_nxt = AW'(ent_r) * AW'(GLYPH_AREA);
          hold_nxt = 1'b0;
          st_nxt = ST_ROW;
        end else begin
          st_nxt = ST_IDLE;
        end
      end
      ST_ROW: begin
        if (row_r >= g_r.h || nsp_r == 5'(MAX_SPANS)) begin
          // flush held span as the final one, then advance the pen
          if (hold_r) begin
            if (!oval_r || !out_stall) begin
              obuf_nxt = hbuf_r; obuf_nxt.last = 1'b1; oval_nxt = 1'b1;
              hold_nxt = 1'b0;
              pen_x_nxt = pen_x_r + 16'(g_r.adv);
              st_nxt = ST_IDLE;
            end
          end else begin
            pen_x_nxt = pen_x_r + 16'(g_r.adv);
            st_nxt = ST_IDLE;
          end
        end else if (!row_vis) begin
          row_nxt = row_r + 5'd1;
          idx_nxt = idx_r + 10'(g_r.w);
        end else begin
          py_nxt = py18[11:0];
          mask_nxt = '0; col_nxt = '0;
          st_nxt = ST_PIX;
        end
      end
      ST_PIX: begin
        // one alpha byte per cycle; read data is registered and returns in the cycle after the address
        if (pend_r && pon_r && al_rd > 8'(ALPHA_THRESHOLD))
          mask_nxt[pcol_r] = 1'b1;
        if (col_r < g_r.w && col_r < 5'(MASK_W)) begin
          pend_nxt = 1'b1;
          pcol_nxt = col_r;
          pon_nxt  = (idx_r < 10'(GLYPH_AREA)) && px18 >= 0 && px18 < 18'(sw);
          col_nxt  = col_r + 5'd1;
          idx_nxt  = idx_r + 10'd1;
        end else if (!pend_r) begin
          st_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        // previous held span goes out (not last); this row becomes held
        if (!hold_r || !oval_r || !out_stall) begin
          if (hold_r) begin
            obuf_nxt = hbuf_r;
            oval_nxt = 1'b1;
          end
          hbuf_nxt = '{row_y: py_r, first_x: fx18[15:0], column_mask: mask_r, last: 1'b0};
          hold_nxt = 1'b1;
          nsp_nxt = nsp_r + 5'd1;
          // back to the row start, then next row
          idx_nxt = idx_r - 10'(col_r) + 10'(g_r.w);
          row_nxt = row_r + 5'd1;
          st_nxt = ST_ROW;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  // a finished span waits in hbuf until the next visible row or the end of the glyph
  logic unused_color;
  assign unused_color = ^color_r;

  property p_no_in_when_busy;
    @(posedge clk) disable iff (!rst_n) (st_r != ST_IDLE) |-> in_stall;
  endproperty
  a_busy: assert property (p_no_in_when_busy) else $error("input taken while busy");

  a_hold_out: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("output changed while stalled");

  a_spans: assert property (@(posedge clk) disable iff (!rst_n)
    (nsp_r <= 5'(MAX_SPANS)) || st_r == ST_IDLE || st_r == ST_DONE)
    else $error("span count overrun");

endmodule

// ----- rtl/gtsr_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module gtsr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
